### rtl/lsss_pkg.sv
package lsss_pkg;

    localparam int unsigned SECTOR_W = 16;
    localparam int unsigned WIDX_W   = 7;
    localparam int unsigned DATA_W   = 32;
    localparam int unsigned USED_W   = 11;

    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_ERASE = 2'd2;

    typedef struct packed {
        logic [1:0]          cmd;
        logic [SECTOR_W-1:0] sector;
        logic [WIDX_W-1:0]   word_index;
        logic [DATA_W-1:0]   word_data;
    } t_item;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              status;
        logic [USED_W-1:0] used_records;
    } t_result;

    // Queue entry: the item plus what the front already worked out about it.
    typedef struct packed {
        t_item item;
        logic  idx_ok;
        logic  idx_last;
    } t_entry;

endpackage

### rtl/lsss_front.sv
module lsss_front #(
    parameter int unsigned WORDS_PER_SECTOR = 128
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  lsss_pkg::t_item   i_item,
    output logic              o_full,
    output logic              o_valid,
    output lsss_pkg::t_entry  o_entry,
    input  logic              i_pop
);

    localparam logic [10:0] WPS = 11'(WORDS_PER_SECTOR);

    lsss_pkg::t_entry r_slot [2];
    logic             r_wr;
    logic             r_rd;
    logic [1:0]       r_cnt;
    lsss_pkg::t_entry n_entry;

    // Classify the word position against the sector size.
    always_comb begin
        n_entry.item     = i_item;
        n_entry.idx_ok   = 11'(i_item.word_index) < WPS;
        n_entry.idx_last = 11'(i_item.word_index) == (WPS - 11'd1);
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr] <= n_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wr <= ~r_wr;
            if (i_pop)  r_rd <= ~r_rd;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    assign o_full  = r_cnt == 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_entry = r_slot[r_rd];

endmodule

### rtl/lsss_back.sv
module lsss_back #(
    parameter int unsigned NUM_RECORDS      = 1024,
    parameter int unsigned WORDS_PER_SECTOR = 128
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  lsss_pkg::t_entry  i_entry,
    output logic              o_pop,
    output logic              o_done,
    output lsss_pkg::t_result o_result
);

    localparam int unsigned IW    = $clog2(NUM_RECORDS);
    localparam int unsigned CW    = $clog2(NUM_RECORDS + 1);
    localparam int unsigned AW    = $clog2(NUM_RECORDS * WORDS_PER_SECTOR);
    localparam int unsigned NSEC  = 2 ** lsss_pkg::SECTOR_W;
    localparam logic [CW-1:0] NREC = CW'(NUM_RECORDS);
    localparam logic [AW-1:0] WPS  = AW'(WORDS_PER_SECTOR);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MAP,
        S_WORD,
        S_OUT
    } t_state;

    logic [lsss_pkg::DATA_W-1:0]   mem_words [NUM_RECORDS * WORDS_PER_SECTOR];
    logic [lsss_pkg::SECTOR_W-1:0] mem_tags  [NUM_RECORDS];
    logic [IW-1:0]                 mem_map   [NSEC];

    t_state                        r_state;
    logic [CW-1:0]                 r_tail;
    logic [AW-1:0]                 r_base;
    logic                          r_pend;
    lsss_pkg::t_entry              r_ent;
    logic [IW-1:0]                 r_map_q;
    logic [AW-1:0]                 r_addr;
    logic [lsss_pkg::SECTOR_W-1:0] r_tag_q;
    logic                          r_hit;
    logic [lsss_pkg::DATA_W-1:0]   r_word_q;
    logic                          r_done;
    lsss_pkg::t_result             r_res;

    logic          full;
    logic          take;
    logic          wr_word;
    logic          rd_look;
    logic          commit;
    logic [AW-1:0] wr_addr;

    assign full    = r_tail == NREC;
    assign take    = (r_state == S_IDLE) && i_valid;
    assign wr_word = take && (i_entry.item.cmd == lsss_pkg::CMD_WRITE)
                     && !full && i_entry.idx_ok;
    assign rd_look = take && (i_entry.item.cmd == lsss_pkg::CMD_READ)
                     && !full && i_entry.idx_ok;
    assign commit  = wr_word && i_entry.idx_last
                     && (r_pend || (i_entry.item.word_data != '0));
    assign wr_addr = r_base + AW'(i_entry.item.word_index);
    assign o_pop   = take;

    // Record storage; the map keeps the newest record per sector.
    always_ff @(posedge i_clk) begin
        if (wr_word) begin
            mem_words[wr_addr] <= i_entry.item.word_data;
        end
        if (commit) begin
            mem_tags[r_tail[IW-1:0]]        <= i_entry.item.sector;
            mem_map[i_entry.item.sector]    <= r_tail[IW-1:0];
        end
        if (take) begin
            r_map_q <= mem_map[i_entry.item.sector];
        end
        if (r_state == S_MAP) begin
            r_tag_q <= mem_tags[r_map_q];
        end
        if (r_state == S_WORD) begin
            r_word_q <= mem_words[r_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_tail  <= '0;
            r_base  <= '0;
            r_pend  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_done <= (take && !rd_look) || (r_state == S_OUT);
            unique case (r_state)
                S_IDLE: begin
                    if (take) begin
                        r_ent           <= i_entry;
                        r_res.read_data <= '0;
                        r_res.status    <= full
                            && ((i_entry.item.cmd == lsss_pkg::CMD_WRITE)
                                || (i_entry.item.cmd == lsss_pkg::CMD_READ));
                        priority if (i_entry.item.cmd == lsss_pkg::CMD_ERASE) begin
                            r_tail             <= '0;
                            r_base             <= '0;
                            r_pend             <= 1'b0;
                            r_res.used_records <= '0;
                        end else if (commit) begin
                            r_tail             <= r_tail + CW'(1);
                            r_base             <= r_base + WPS;
                            r_pend             <= 1'b0;
                            r_res.used_records <= lsss_pkg::USED_W'(r_tail + CW'(1));
                        end else begin
                            r_res.used_records <= lsss_pkg::USED_W'(r_tail);
                            if (wr_word) begin
                                r_pend <= !i_entry.idx_last
                                          && (r_pend || (i_entry.item.word_data != '0));
                            end
                        end
                        if (rd_look) begin
                            r_state <= S_MAP;
                        end
                    end
                end
                S_MAP: begin
                    r_addr  <= AW'(r_map_q) * WPS + AW'(r_ent.item.word_index);
                    r_hit   <= CW'(r_map_q) < r_tail;
                    r_state <= S_WORD;
                end
                S_WORD: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (r_hit && (r_tag_q == r_ent.item.sector)) begin
                        r_res.read_data <= r_word_q;
                    end
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_done   = r_done;
    assign o_result = r_res;

endmodule

### rtl/log_structured_sector_store_core.sv
// Any item other than a read that looks up the log passes a queue slot and then the
// registered done flag; such a read also walks the states S_MAP, S_WORD and S_OUT first.
// Throughput: one write word per cycle while no read holds the log engine; a read holds
// it until it has walked the sector map, tag store and word store one port after another.
// Reset (synchronous, active low) empties the log and the queue; memories keep contents.
// Results leave on o_done for one cycle and cannot be held off.
module log_structured_sector_store_core #(
    parameter int unsigned NUM_RECORDS      = 1024,
    parameter int unsigned WORDS_PER_SECTOR = 128
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  lsss_pkg::t_item   i_item,
    output logic              o_done,
    output lsss_pkg::t_result o_result
);

    // Transaction queue between the classifier and the log engine.
    logic             q_full;
    logic             q_valid;
    logic             q_pop;
    lsss_pkg::t_entry q_entry;

    // Hold off the next transaction only while the queue is full.
    assign busy = q_full;

    lsss_front #(
        .WORDS_PER_SECTOR(WORDS_PER_SECTOR)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (start && !q_full),
        .i_item  (i_item),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_entry (q_entry),
        .i_pop   (q_pop)
    );

    // Carry out writes, commits, reads through the sector map, and erase.
    lsss_back #(
        .NUM_RECORDS      (NUM_RECORDS),
        .WORDS_PER_SECTOR (WORDS_PER_SECTOR)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .i_entry  (q_entry),
        .o_pop    (q_pop),
        .o_done   (o_done),
        .o_result (o_result)
    );

endmodule

### sim/log_structured_sector_store_core_tb.sv
module log_structured_sector_store_core_tb;

    localparam int unsigned NUM_REC   = 1024;
    localparam int unsigned WORDS     = 128;
    localparam logic [1:0]  CMD_SPARE = 2'd3;   // no operation, answers ok
    localparam int          TARGET    = 1800;

    // Mirror of the sector log: contents, tags, tail and the pending flag,
    // plus the results still owed by the block, oldest first.
    class sector_log_tracker;
        bit [31:0]         words[NUM_REC*WORDS];
        bit                written[NUM_REC*WORDS];
        bit [15:0]         tags[NUM_REC];
        int unsigned       tail;
        bit                pend;
        lsss_pkg::t_result owed[$];
        int                errors;

        function int newest_record(bit [15:0] sec);
            for (int r = int'(tail) - 1; r >= 0; r--) begin
                if (tags[r] == sec) return r;
            end
            return -1;
        endfunction

        // A read may only land on a word that has been written since reset.
        function bit read_allowed(lsss_pkg::t_item it);
            int r;
            if (it.cmd != lsss_pkg::CMD_READ || tail >= NUM_REC) return 1;
            r = newest_record(it.sector);
            if (r < 0) return 1;
            return written[r*WORDS + it.word_index];
        endfunction

        function void note_item(lsss_pkg::t_item it);
            lsss_pkg::t_result res;
            int                r;
            int                slot;
            bit                full;
            full = (tail >= NUM_REC);
            res  = '0;
            case (it.cmd)
                lsss_pkg::CMD_WRITE: begin
                    if (full) begin
                        res.status = 1'b1;
                    end else if (it.word_index < WORDS) begin
                        slot          = tail*WORDS + it.word_index;
                        words[slot]   = it.word_data;
                        written[slot] = 1'b1;
                        if (it.word_data != 0) pend = 1'b1;
                        if (it.word_index == WORDS - 1) begin
                            if (pend) begin
                                tags[tail] = it.sector;
                                tail++;
                            end
                            pend = 1'b0;
                        end
                    end
                end
                lsss_pkg::CMD_READ: begin
                    if (full) begin
                        res.status = 1'b1;
                    end else if (it.word_index < WORDS) begin
                        r = newest_record(it.sector);
                        if (r >= 0) res.read_data = words[r*WORDS + it.word_index];
                    end
                end
                lsss_pkg::CMD_ERASE: begin
                    tail = 0;
                    pend = 1'b0;
                end
                default: ;
            endcase
            res.used_records = tail[lsss_pkg::USED_W-1:0];
            owed.push_back(res);
        endfunction

        function void check_result(lsss_pkg::t_result got);
            lsss_pkg::t_result exp;
            if (owed.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            exp = owed.pop_front();
            if (got.read_data !== exp.read_data) begin
                $display("%0t: read_data expected %h actual %h",
                         $time, exp.read_data, got.read_data);
                errors++;
            end
            if (got.status !== exp.status) begin
                $display("%0t: status expected %0d actual %0d",
                         $time, exp.status, got.status);
                errors++;
            end
            if (got.used_records !== exp.used_records) begin
                $display("%0t: used_records expected %0d actual %0d",
                         $time, exp.used_records, got.used_records);
                errors++;
            end
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    lsss_pkg::t_item   i_item;
    logic              o_done;
    lsss_pkg::t_result o_result;

    sector_log_tracker log_mirror;
    int      sent;
    bit      idling_on;

    log_structured_sector_store_core #(
        .NUM_RECORDS      (NUM_REC),
        .WORDS_PER_SECTOR (WORDS)
    ) DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_done   (o_done),
        .o_result (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Results cannot be held off: take each one on the edge that ends its strobe.
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) log_mirror.check_result(o_result);
    end

    // Hold the sender low for a number of cycles.
    task automatic pause_sender(int n);
        repeat (n) begin
            @(negedge i_clk);
            start = 1'b0;
        end
    endtask

    // Drive one transaction and wait for it to be taken. A read that would land
    // on a word never written since reset is turned into the spare command.
    // busy only moves on a rising edge, so read it at the falling edge before.
    task automatic send_item(lsss_pkg::t_item it);
        bit took;
        if (!log_mirror.read_allowed(it)) it.cmd = CMD_SPARE;
        if (idling_on && $urandom_range(0, 9) == 0) pause_sender(int'($urandom_range(1, 13)));
        @(negedge i_clk);
        start  = 1'b1;
        i_item = it;
        forever begin
            took = !busy;
            @(posedge i_clk);
            if (took) break;
            @(negedge i_clk);
        end
        log_mirror.note_item(it);
        sent++;
    endtask

    task automatic send_fields(logic [1:0] cmd, logic [15:0] sec, logic [6:0] idx,
                               logic [31:0] data);
        lsss_pkg::t_item it;
        it.cmd        = cmd;
        it.sector     = sec;
        it.word_index = idx;
        it.word_data  = data;
        send_item(it);
    endtask

    // Stop sending until every owed result is in, then let the pipeline settle.
    task automatic drain_results(int limit);
        int n;
        @(negedge i_clk);
        start = 1'b0;
        n = 0;
        while (log_mirror.owed.size() != 0 && n < limit) begin
            @(posedge i_clk);
            n++;
        end
        repeat (10) @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_data();
        case ($urandom_range(0, 5))
            0:       return 32'h0;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // A few hot sectors so that reads find something, with the odd stray one.
    function automatic logic [15:0] pick_sector();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'($urandom);
            default: return 16'(16'h0010 + $urandom_range(0, 4));
        endcase
    endfunction

    function automatic logic [6:0] pick_index();
        if ($urandom_range(0, 3) == 0) return 7'($urandom);
        return 7'($urandom_range(0, 3));
    endfunction

    task automatic random_traffic();
        logic [15:0] sec;
        int          kind;
        kind = $urandom_range(0, 99);
        if (kind < 45) begin
            // short sector write with random content; earlier words may carry
            // another sector, only the closing word's tag counts
            sec = pick_sector();
            repeat ($urandom_range(0, 6)) begin
                send_fields(lsss_pkg::CMD_WRITE,
                            ($urandom_range(0, 3) == 0) ? pick_sector() : sec,
                            pick_index(), pick_data());
            end
            if ($urandom_range(0, 9) != 0) begin
                send_fields(lsss_pkg::CMD_WRITE, sec, 7'd127, pick_data());
            end
        end else if (kind < 88) begin
            send_fields(lsss_pkg::CMD_READ, pick_sector(), pick_index(), $urandom);
        end else if (kind < 90) begin
            send_fields(lsss_pkg::CMD_ERASE, 16'($urandom), 7'($urandom), $urandom);
        end else begin
            send_fields(2'($urandom), 16'($urandom), 7'($urandom), $urandom);
        end
    endtask

    initial begin
        log_mirror = new();
        sent       = 0;
        idling_on  = 1'b0;
        start      = 1'b0;
        i_item     = '0;
        i_rst_n    = 1'b0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: empty log, spare command, all-zero record, commit tag taken
        // from the closing word, index limits and data extremes.
        send_fields(lsss_pkg::CMD_READ, 16'h0000, 7'd0, 32'hFFFF_FFFF);
        send_fields(lsss_pkg::CMD_READ, 16'hFFFF, 7'd127, 32'h0);
        send_fields(CMD_SPARE, 16'hFFFF, 7'd127, 32'hFFFF_FFFF);
        send_fields(lsss_pkg::CMD_WRITE, 16'h0001, 7'd0, 32'h0);
        send_fields(lsss_pkg::CMD_WRITE, 16'h0001, 7'd127, 32'h0);
        send_fields(lsss_pkg::CMD_READ, 16'h0001, 7'd0, 32'h0);
        send_fields(lsss_pkg::CMD_WRITE, 16'h0000, 7'd0, 32'hFFFF_FFFF);
        send_fields(lsss_pkg::CMD_WRITE, 16'hFFFF, 7'd127, 32'h0);
        send_fields(lsss_pkg::CMD_READ, 16'hFFFF, 7'd0, 32'h0);
        send_fields(lsss_pkg::CMD_READ, 16'hFFFF, 7'd127, 32'h0);
        send_fields(lsss_pkg::CMD_READ, 16'h0000, 7'd0, 32'h0);
        send_fields(lsss_pkg::CMD_WRITE, 16'hFFFF, 7'd0, 32'h0000_0001);
        send_fields(lsss_pkg::CMD_WRITE, 16'hFFFF, 7'd127, 32'h8000_0000);
        send_fields(lsss_pkg::CMD_READ, 16'hFFFF, 7'd0, 32'h0);
        send_fields(lsss_pkg::CMD_READ, 16'hFFFF, 7'd127, 32'h0);
        send_fields(lsss_pkg::CMD_ERASE, 16'hFFFF, 7'd127, 32'hFFFF_FFFF);
        send_fields(lsss_pkg::CMD_READ, 16'hFFFF, 7'd0, 32'h0);
        // stale words survive the erase; a fresh commit reuses them
        send_fields(lsss_pkg::CMD_WRITE, 16'h0002, 7'd127, 32'h5A5A_A5A5);
        send_fields(lsss_pkg::CMD_READ, 16'h0002, 7'd0, 32'h0);
        send_fields(lsss_pkg::CMD_READ, 16'h0002, 7'd127, 32'h0);
        drain_results(1000);

        idling_on = 1'b1;
        while (sent < 900) begin
            if ($urandom_range(0, 99) == 0) idling_on = ~idling_on;
            random_traffic();
        end
        drain_results(1000);

        idling_on = 1'b1;
        while (sent < TARGET - 200) begin
            if ($urandom_range(0, 99) == 0) idling_on = ~idling_on;
            random_traffic();
        end
        idling_on = 1'b0;
        while (sent < TARGET) random_traffic();

        drain_results(100000);
        if (log_mirror.owed.size() == 0 && log_mirror.errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

### filelist.f
rtl/lsss_pkg.sv
rtl/lsss_front.sv
rtl/lsss_back.sv
rtl/log_structured_sector_store_core.sv
sim/log_structured_sector_store_core_tb.sv
